### design/pgr_pkg.sv
// Package for the potential grid relaxation block.
// Shared widths, ops and constants. No dependencies.
package pgr_pkg;
	localparam int GRID_ROWS = 32;
	localparam int GRID_COLS = 64;
	localparam int ROW_W = 5;
	localparam int COL_W = 6;
	localparam int POT_W = 24;
	localparam int ERR_W = 48;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 19;
	localparam logic signed [POT_W-1:0] ONE_Q16 = 24'sd65536;
	localparam logic signed [POT_W-1:0] POT_MAX = 24'sd8388607;
	localparam logic signed [POT_W-1:0] POT_MIN = -24'sd8388608;
	localparam logic [16:0] RELAX_RST = 17'd52429;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_SWEEP = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RELAX = 2'd0,
		REG_GAIN_X = 2'd1,
		REG_GAIN_Y = 2'd2,
		REG_SPARE = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] op;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic signed [POT_W-1:0] cell_value;
	} req_t;

	typedef struct packed {
		logic signed [POT_W-1:0] read_value;
		logic cell_free;
		logic [ERR_W-1:0] error_sum;
	} rsp_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_t;

	typedef struct packed {
		logic [16:0] relax;
		logic signed [18:0] gx;
		logic signed [18:0] gy;
	} coef_t;

	function automatic logic is_free(input logic signed [POT_W-1:0] p);
		return (p != '0) && (p != ONE_Q16);
	endfunction
endpackage

### design/pgr_if.sv
// Valid/ready channel interfaces for the relaxation block.
// Depends on pgr_pkg.
interface pgr_req_if;
	logic valid;
	logic ready;
	pgr_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pgr_rsp_if;
	logic valid;
	logic ready;
	pgr_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface pgr_cfg_if;
	logic valid;
	logic ready;
	pgr_pkg::cfg_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### design/potential_grid_relaxation.sv
// Top level of the potential grid relaxation block.
// Request, response and configuration channels; register file and sweep core.
// Depends on pgr_pkg, pgr_if, pgr_regs, pgr_core.
//
// Use: write cells (op 0), read one back (op 1), or run one in-place
// Gauss-Seidel sweep over the grid (op 2). Each request gives one response.
// A sweep reads the old value of each cell and, for a free cell, its four
// neighbors in turn over one read port. Requests are taken one at a time;
// a new request is accepted once the previous response has been taken.
// Configuration writes: always ready; issue only while idle.
// Reset clears the registers to relax 0.8, zero gains, and the control
// state; grid contents are undefined until written. A stalled receiver
// holds the response register and blocks the next request.
module potential_grid_relaxation #(
	parameter int GRID_ROWS = pgr_pkg::GRID_ROWS,
	parameter int GRID_COLS = pgr_pkg::GRID_COLS
) (
	input logic clk,
	input logic arst_n,
	pgr_req_if.sink req,
	pgr_rsp_if.source rsp,
	pgr_cfg_if.sink cfg
);
	pgr_pkg::coef_t coef;

	pgr_regs u_regs (.clk, .arst_n, .cfg, .coef);

	pgr_core #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_core (
		.clk, .arst_n, .coef, .req, .rsp
	);
endmodule

### design/pgr_regs.sv
// Configuration registers of the relaxation block.
// Depends on pgr_pkg.
module pgr_regs (
	input  logic clk,
	input  logic arst_n,
	pgr_cfg_if.sink cfg,
	output pgr_pkg::coef_t coef
);
	logic [16:0] relax_q;
	logic signed [18:0] gx_q, gy_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			relax_q <= pgr_pkg::RELAX_RST;
			gx_q <= '0;
			gy_q <= '0;
		end else if (cfg.valid) begin
			case (pgr_pkg::reg_idx_t'(cfg.data.index))
				pgr_pkg::REG_RELAX: relax_q <= cfg.data.data[16:0];
				pgr_pkg::REG_GAIN_X: gx_q <= cfg.data.data;
				pgr_pkg::REG_GAIN_Y: gy_q <= cfg.data.data;
				default: ;
			endcase
		end
	end

	assign coef = '{relax: relax_q, gx: gx_q, gy: gy_q};
endmodule

### design/pgr_core.sv
// Grid memory and sweep sequencer: read old value and neighbors one per cycle,
// compute the relaxed value over sequential steps, write back. Depends on pgr_pkg.
module pgr_core #(
	parameter int GRID_ROWS = pgr_pkg::GRID_ROWS,
	parameter int GRID_COLS = pgr_pkg::GRID_COLS
) (
	input  logic clk,
	input  logic arst_n,
	input  pgr_pkg::coef_t coef,
	pgr_req_if.sink req,
	pgr_rsp_if.source rsp
);
	localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
	localparam int CW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
	localparam int AW = RW + CW;
	localparam int DEPTH = 1 << AW;
	localparam int PW = pgr_pkg::POT_W;
	localparam int EW = pgr_pkg::ERR_W;

	typedef enum logic [3:0] {
		S_IDLE, S_RD, S_OLD, S_TOP, S_BOT, S_LFT, S_RGT,
		S_ACC, S_MEAN, S_MUL, S_NEW, S_SQ, S_WB, S_OUT
	} state_t;

	logic signed [PW-1:0] mem [DEPTH];
	logic [AW-1:0] raddr;
	logic signed [PW-1:0] rdata_q;
	logic we;
	logic [AW-1:0] waddr;
	logic signed [PW-1:0] wdata;

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	state_t state_q;
	logic [1:0] op_q;
	logic [RW-1:0] r_q;
	logic [CW-1:0] c_q;
	logic inside_q;
	logic signed [PW-1:0] old_q, top_q, bot_q, lft_q, rgt_q, nv_q;
	logic signed [47:0] acc_q;
	logic signed [25:0] m_q;
	logic signed [44:0] prod_q;
	logic [EW-1:0] err_q;
	logic [EW-1:0] sq_q;
	logic signed [PW-1:0] val_q;
	logic out_valid_q;
	pgr_pkg::rsp_t out_q;
	pgr_pkg::rsp_t out_d;

	logic last_r, last_c, top_in, bot_in, lft_in, rgt_in;
	assign last_r = (32'(r_q) == GRID_ROWS - 1);
	assign last_c = (32'(c_q) == GRID_COLS - 1);
	assign top_in = (r_q != '0);
	assign bot_in = !last_r;
	assign lft_in = (c_q != '0);
	assign rgt_in = !last_c;

	logic [RW-1:0] r_m1, r_p1;
	logic [CW-1:0] c_m1, c_p1;
	assign r_m1 = r_q - 1'b1;
	assign r_p1 = r_q + 1'b1;
	assign c_m1 = c_q - 1'b1;
	assign c_p1 = c_q + 1'b1;

	always_comb begin
		case (state_q)
			S_OLD: raddr = {r_m1, c_q};
			S_TOP: raddr = {r_p1, c_q};
			S_BOT: raddr = {r_q, c_m1};
			S_LFT: raddr = {r_q, c_p1};
			default: raddr = {r_q, c_q};
		endcase
	end

	logic signed [PW-1:0] rd_nb;
	always_comb begin
		rd_nb = rdata_q;
		case (state_q)
			S_TOP: if (!top_in) rd_nb = pgr_pkg::ONE_Q16;
			S_BOT: if (!bot_in) rd_nb = pgr_pkg::ONE_Q16;
			S_LFT: if (!lft_in) rd_nb = pgr_pkg::ONE_Q16;
			S_RGT: if (!rgt_in) rd_nb = pgr_pkg::ONE_Q16;
			default: ;
		endcase
	end

	// weighted neighbor sum, exact
	logic signed [19:0] wxp, wxm, wyp, wym;
	logic signed [47:0] acc_d;
	assign wxp = 20'sd65536 + 20'(coef.gx);
	assign wxm = 20'sd65536 - 20'(coef.gx);
	assign wyp = 20'sd65536 + 20'(coef.gy);
	assign wym = 20'sd65536 - 20'(coef.gy);
	always_comb begin
		acc_d = 48'(wxp * rgt_q) + 48'(wxm * lft_q) + 48'(wyp * top_q) + 48'(wym * bot_q);
	end

	logic signed [26:0] diff;
	assign diff = 27'(m_q) - 27'(old_q);
	logic signed [44:0] mul_d;
	assign mul_d = 45'(diff * $signed({1'b0, coef.relax}));
	logic signed [29:0] nv_raw;
	assign nv_raw = 30'(m_q) + 30'(prod_q >>> 16);
	logic signed [PW-1:0] nv_sat;
	always_comb begin
		if (nv_raw > 30'(pgr_pkg::POT_MAX)) nv_sat = pgr_pkg::POT_MAX;
		else if (nv_raw < 30'(pgr_pkg::POT_MIN)) nv_sat = pgr_pkg::POT_MIN;
		else nv_sat = nv_raw[PW-1:0];
	end
	logic signed [PW:0] dlt;
	logic [PW:0] dabs;
	assign dlt = 25'(nv_q) - 25'(old_q);
	assign dabs = dlt[PW] ? 25'(-dlt) : 25'(dlt);
	logic [EW:0] esum;
	assign esum = {1'b0, err_q} + {1'b0, sq_q};

	logic free_old;
	assign free_old = pgr_pkg::is_free(rdata_q);

	assign req.ready = (state_q == S_IDLE) && !out_valid_q;
	assign rsp.valid = out_valid_q;
	assign rsp.data = out_q;

	always_comb begin
		out_d = '0;
		case (pgr_pkg::op_t'(op_q))
			pgr_pkg::OP_READ: if (inside_q) begin
				out_d.read_value = rdata_q;
				out_d.cell_free = pgr_pkg::is_free(rdata_q);
			end
			pgr_pkg::OP_SWEEP: out_d.error_sum = err_q;
			default: ;
		endcase
	end

	always_comb begin
		we = 1'b0;
		waddr = {r_q, c_q};
		wdata = nv_q;
		if (state_q == S_WB) we = 1'b1;
		if (req.valid && req.ready && req.data.op == pgr_pkg::OP_WRITE
			&& 32'(req.data.row) < GRID_ROWS && 32'(req.data.col) < GRID_COLS) begin
			we = 1'b1;
			waddr = {RW'(req.data.row), CW'(req.data.col)};
			wdata = req.data.cell_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: if (req.valid && req.ready) begin
					op_q <= req.data.op;
					inside_q <= 32'(req.data.row) < GRID_ROWS && 32'(req.data.col) < GRID_COLS;
					r_q <= (req.data.op == pgr_pkg::OP_SWEEP) ? '0 : RW'(req.data.row);
					c_q <= (req.data.op == pgr_pkg::OP_SWEEP) ? '0 : CW'(req.data.col);
					err_q <= '0;
					state_q <= (req.data.op == pgr_pkg::OP_READ
						|| req.data.op == pgr_pkg::OP_SWEEP) ? S_RD : S_OUT;
				end
				S_RD: begin
					if (op_q == pgr_pkg::OP_READ) state_q <= S_OUT;
					else state_q <= S_OLD;
					val_q <= '0;
				end
				S_OLD: begin
					old_q <= rdata_q;
					val_q <= rdata_q;
					state_q <= free_old ? S_TOP : S_SQ;
				end
				S_TOP: begin top_q <= rd_nb; state_q <= S_BOT; end
				S_BOT: begin bot_q <= rd_nb; state_q <= S_LFT; end
				S_LFT: begin lft_q <= rd_nb; state_q <= S_RGT; end
				S_RGT: begin rgt_q <= rd_nb; state_q <= S_ACC; end
				S_ACC: begin acc_q <= acc_d; state_q <= S_MEAN; end
				S_MEAN: begin m_q <= 26'(acc_q >>> 18); state_q <= S_MUL; end
				S_MUL: begin prod_q <= mul_d; state_q <= S_NEW; end
				S_NEW: begin nv_q <= nv_sat; state_q <= S_WB; end
				S_WB: begin
					sq_q <= EW'(dabs * dabs);
					state_q <= S_SQ;
				end
				S_SQ: begin
					// fixed cells skip update; sq_q only valid after S_WB
					if (pgr_pkg::is_free(val_q)) begin
						err_q <= esum[EW] ? '1 : esum[EW-1:0];
					end
					if (last_c && last_r) state_q <= S_OUT;
					else begin
						if (last_c) begin
							c_q <= '0;
							r_q <= r_p1;
						end else c_q <= c_p1;
						state_q <= S_RD;
					end
				end
				S_OUT: begin
					out_valid_q <= 1'b1;
					out_q <= out_d;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> !req.ready) else $error("accept while busy");
	a_out_after: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT) |=> out_valid_q) else $error("missing result");
	a_wb_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WB) |-> pgr_pkg::is_free(old_q)) else $error("fixed cell written");
endmodule

### test/potential_grid_relaxation_tb.sv
// Testbench for potential_grid_relaxation: loads the grid, then runs reads, writes and sweeps
// under several relax and gain settings, and checks each response against a local predictor.
// Depends on pgr_pkg, pgr_if and the block's RTL.
module potential_grid_relaxation_tb;
	import pgr_pkg::*;

	localparam int NCELLS = GRID_ROWS * GRID_COLS;
	localparam longint ERR_SAT = 64'hFFFF_FFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pgr_req_if req_ch();
	pgr_rsp_if rsp_ch();
	pgr_cfg_if cfg_ch();

	potential_grid_relaxation uut (
		.clk(clk), .arst_n(arst_n), .req(req_ch), .rsp(rsp_ch), .cfg(cfg_ch)
	);

	always #5 clk = ~clk;

	req_t pend_q[$];
	rsp_t resp_q[$];
	logic signed [POT_W-1:0] grid_model [NCELLS];
	logic [16:0] relax_w = RELAX_RST;
	logic signed [18:0] gain_x_w = '0;
	logic signed [18:0] gain_y_w = '0;
	bit quiet = 0;
	int n_fail = 0;
	int gap, stall, hold, taken;
	bit held;

	function automatic longint neighbor(int r, int c);
		if (r < 0 || r >= GRID_ROWS || c < 0 || c >= GRID_COLS)
			return 65536;
		return longint'(grid_model[r * GRID_COLS + c]);
	endfunction

	function automatic longint sweep_grid();
		longint err, old, acc, m, nv, d, sq;
		err = 0;
		for (int r = 0; r < GRID_ROWS; r++) begin
			for (int c = 0; c < GRID_COLS; c++) begin
				old = longint'(grid_model[r * GRID_COLS + c]);
				if (old == 0 || old == 65536)
					continue;
				acc = (65536 + longint'(gain_x_w)) * neighbor(r, c + 1)
					+ (65536 - longint'(gain_x_w)) * neighbor(r, c - 1)
					+ (65536 + longint'(gain_y_w)) * neighbor(r - 1, c)
					+ (65536 - longint'(gain_y_w)) * neighbor(r + 1, c);
				m = acc >>> 18;
				nv = m + ((longint'(relax_w) * (m - old)) >>> 16);
				if (nv > 8388607)
					nv = 8388607;
				if (nv < -8388608)
					nv = -8388608;
				d = nv - old;
				sq = d * d;
				if (sq > ERR_SAT - err)
					err = ERR_SAT;
				else
					err += sq;
				grid_model[r * GRID_COLS + c] = nv[POT_W-1:0];
			end
		end
		return err;
	endfunction

	function automatic rsp_t apply_request(req_t q);
		rsp_t o;
		int idx;
		o = '0;
		idx = int'(q.row) * GRID_COLS + int'(q.col);
		case (q.op)
			OP_WRITE: grid_model[idx] = q.cell_value;
			OP_READ: begin
				o.read_value = grid_model[idx];
				o.cell_free = (grid_model[idx] != 0) && (grid_model[idx] != 65536);
			end
			OP_SWEEP: o.error_sum = sweep_grid();
			default: ;
		endcase
		return o;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.data <= '0;
			gap <= 0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				resp_q.push_back(apply_request(req_ch.data));
			if (!req_ch.valid || req_ch.ready) begin
				if (gap > 0) begin
					gap <= gap - 1;
					req_ch.valid <= 1'b0;
				end else if (pend_q.size() > 0) begin
					req_ch.valid <= 1'b1;
					req_ch.data <= pend_q.pop_front();
					if (!quiet && $urandom_range(0, 5) == 0)
						gap <= $urandom_range(1, 5);
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// response monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall <= 0;
			hold <= 0;
			taken <= 0;
			held <= 0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				taken <= taken + 1;
				if (resp_q.size() == 0) begin
					$error("response with no request pending");
					n_fail++;
				end else begin
					e = resp_q.pop_front();
					if (rsp_ch.data.read_value !== e.read_value) begin
						$error("read_value expected %0d actual %0d", e.read_value,
							rsp_ch.data.read_value);
						n_fail++;
					end
					if (rsp_ch.data.cell_free !== e.cell_free) begin
						$error("cell_free expected %0d actual %0d", e.cell_free,
							rsp_ch.data.cell_free);
						n_fail++;
					end
					if (rsp_ch.data.error_sum !== e.error_sum) begin
						$error("error_sum expected %0d actual %0d", e.error_sum,
							rsp_ch.data.error_sum);
						n_fail++;
					end
				end
			end
			if (!held && taken == 40) begin
				held <= 1;
				hold <= 300;
				rsp_ch.ready <= 1'b0;
			end else if (hold > 0) begin
				hold <= hold - 1;
				rsp_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				stall <= stall - 1;
				rsp_ch.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				stall <= $urandom_range(0, 4);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// register writes seen by the predictor
	always @(posedge clk) begin
		if (arst_n && cfg_ch.valid && cfg_ch.ready) begin
			case (reg_idx_t'(cfg_ch.data.index))
				REG_RELAX: relax_w = cfg_ch.data.data[16:0];
				REG_GAIN_X: gain_x_w = cfg_ch.data.data;
				REG_GAIN_Y: gain_y_w = cfg_ch.data.data;
				default: ;
			endcase
		end
	end

	function automatic logic [POT_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return 24'd65536;
			2: return 24'($urandom());
			3: return ($urandom_range(0, 1)) ? 24'h7FFFFF : 24'h800000;
			default: return 24'($urandom_range(0, 262144)) - 24'd131072;
		endcase
	endfunction

	function automatic req_t make_req(op_t op, int r, int c, logic [POT_W-1:0] v);
		req_t q;
		q.op = op;
		q.row = r[ROW_W-1:0];
		q.col = c[COL_W-1:0];
		q.cell_value = v;
		return q;
	endfunction

	function automatic req_t rand_req();
		int k;
		k = $urandom_range(0, 99);
		if (k < 2)
			return make_req(OP_SWEEP, $urandom, $urandom, 24'($urandom));
		if (k < 7)
			return make_req(OP_NONE, $urandom, $urandom, 24'($urandom));
		if (k < 27)
			return make_req(OP_READ, $urandom, $urandom, 24'($urandom));
		return make_req(OP_WRITE, $urandom, $urandom, pick_value());
	endfunction

	task automatic wait_idle();
		while (pend_q.size() > 0 || resp_q.size() > 0 || req_ch.valid)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] v);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= {idx, v};
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic set_coefs(logic [CFG_DATA_W-1:0] rl, logic [CFG_DATA_W-1:0] gx,
			logic [CFG_DATA_W-1:0] gy);
		wait_idle();
		write_reg(REG_RELAX, rl);
		write_reg(REG_GAIN_X, gx);
		write_reg(REG_GAIN_Y, gy);
	endtask

	initial begin
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < NCELLS; i++)
			pend_q.push_back(make_req(OP_WRITE, i / GRID_COLS, i % GRID_COLS, pick_value()));
		pend_q.push_back(make_req(OP_WRITE, 0, 0, 24'h7FFFFF));
		pend_q.push_back(make_req(OP_WRITE, 31, 63, 24'h800000));
		pend_q.push_back(make_req(OP_WRITE, 0, 63, 24'd0));
		pend_q.push_back(make_req(OP_WRITE, 31, 0, 24'd65536));
		pend_q.push_back(make_req(OP_WRITE, 5, 7, 24'd65535));
		pend_q.push_back(make_req(OP_WRITE, 5, 8, 24'd65537));
		pend_q.push_back(make_req(OP_READ, 0, 0, 24'hFFFFFF));
		pend_q.push_back(make_req(OP_READ, 31, 63, 0));
		pend_q.push_back(make_req(OP_READ, 0, 63, 0));
		pend_q.push_back(make_req(OP_READ, 31, 0, 0));
		pend_q.push_back(make_req(OP_READ, 5, 7, 0));
		pend_q.push_back(make_req(OP_NONE, 31, 63, 24'hFFFFFF));
		pend_q.push_back(make_req(OP_SWEEP, 0, 0, 0));
		pend_q.push_back(make_req(OP_READ, 5, 8, 0));

		set_coefs(19'd0, 19'd131072, -19'sd131072);
		pend_q.push_back(make_req(OP_SWEEP, 0, 0, 0));
		set_coefs(19'd65536, -19'sd131072, 19'd131072);
		pend_q.push_back(make_req(OP_SWEEP, 0, 0, 0));
		pend_q.push_back(make_req(OP_READ, 10, 20, 0));
		set_coefs(19'd131071, 19'h40000, 19'h3FFFF);
		pend_q.push_back(make_req(OP_SWEEP, 0, 0, 0));

		for (int ph = 0; ph < 3; ph++) begin
			set_coefs(19'($urandom_range(0, 65536)), 19'($urandom_range(0, 262144) - 131072),
				19'($urandom_range(0, 262144) - 131072));
			if (ph == 2) begin
				wait_idle();
				quiet = 1;
			end
			for (int i = 0; i < 97; i++)
				pend_q.push_back(rand_req());
			pend_q.push_back(make_req(OP_SWEEP, 0, 0, 0));
		end

		wait_idle();
		repeat (50) @(posedge clk);
		if (n_fail == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#40000000;
		$display("TEST FAILED");
		$finish;
	end
endmodule
